### hw/rtl/pspc_pkg.sv
// Shared types and constants for the page private/shared classifier.
// No dependencies; imported by pspc_table and page_private_shared_classifier.
`default_nettype none

package pspc_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int TAG_W = 40;
   localparam int FLAG_W = 12;
   localparam int OWNER_W = 8;
   localparam int ADDR_W = 52;
   localparam int PAGE_LSB = 12;

   // flag word: owner in the low byte, then the state bits
   localparam int F_PRIVATE = 8;
   localparam int F_LOCK = 9;
   localparam int F_INSERT = 10;
   localparam int F_RELEASE = 11;

   typedef enum logic [1:0] {
      OP_ACCESS = 2'd0,
      OP_WALK   = 2'd1,
      OP_QUERY  = 2'd2,
      OP_RECORD = 2'd3
   } op_type;

   typedef struct packed {
      logic              hit;
      logic [FLAG_W-1:0] flags;
      logic              room;
   } lookup_type;

   typedef struct packed {
      logic              upd_we;
      logic [FLAG_W-1:0] upd_flags;
      logic              ins_we;
      logic [FLAG_W-1:0] ins_flags;
   } write_type;

endpackage

`default_nettype wire

### hw/rtl/page_private_shared_classifier.sv
// Page private/shared classifier, top level.
// A request is held in the input register, then looked up and one entry
// read-modified-written, with the result going into the result register.
// Throughput: one request per cycle while rsp_stall does not hold the result
// register. Reset empties the table at once (fill count cleared).
`default_nettype none

module page_private_shared_classifier
   import pspc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [1:0]        req_op,
   input  wire logic [ADDR_W-1:0] req_address_or_entry,
   input  wire logic [7:0]        req_requester,
   input  wire logic              req_retry_ok,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_is_private,
   output logic                   rsp_trigger,
   output logic [7:0]             rsp_keeper,
   output logic                   rsp_hit,
   output logic                   rsp_entry_present,
   output logic                   rsp_table_full
);

   logic               s1_valid_ff;
   op_type             s1_op_ff;
   logic [TAG_W-1:0]   s1_tag_ff;
   logic               s1_pbit_ff;
   logic [OWNER_W-1:0] s1_req_ff;
   logic               s1_retry_ff;

   logic               rsp_valid_ff;
   logic               prv_ff, trig_ff, hit_ff, present_ff, full_ff;
   logic [OWNER_W-1:0] keeper_ff;

   logic               prv_in, trig_in, hit_in, present_in, full_in;
   logic [OWNER_W-1:0] keeper_in;
   logic               fire;
   logic               foreign;
   logic               insert;
   logic [FLAG_W-1:0]  ins_base;
   lookup_type         lk;
   write_type          wr_raw;
   write_type          wr;

   pspc_table u_table (
      .clock  (clock),
      .reset  (reset),
      .lk_tag (s1_tag_ff),
      .lk     (lk),
      .wr     (wr)
   );

   assign fire      = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall) begin
         s1_op_ff    <= op_type'(req_op);
         s1_tag_ff   <= req_address_or_entry[ADDR_W-1:PAGE_LSB];
         s1_pbit_ff  <= req_address_or_entry[0];
         s1_req_ff   <= req_requester;
         s1_retry_ff <= req_retry_ok;
      end
   end

   assign foreign = lk.flags[F_PRIVATE] && (lk.flags[OWNER_W-1:0] != s1_req_ff);

   always_comb begin
      prv_in     = 1'b0;
      trig_in    = 1'b0;
      hit_in     = lk.hit;
      present_in = 1'b0;
      full_in    = 1'b0;
      keeper_in  = lk.hit ? lk.flags[OWNER_W-1:0] : '0;
      insert     = 1'b0;
      ins_base   = '0;
      wr_raw     = '0;
      unique case (s1_op_ff)
         OP_ACCESS: begin
            if (!lk.hit) begin
               prv_in    = 1'b1;
               keeper_in = s1_req_ff;
               insert    = 1'b1;
               ins_base  = FLAG_W'(1) << F_INSERT;
            end else if (foreign) begin
               wr_raw.upd_we    = 1'b1;
               wr_raw.upd_flags = lk.flags;
               if (!s1_retry_ff) begin
                  prv_in  = 1'b1;
                  trig_in = 1'b1;
                  wr_raw.upd_flags[F_LOCK] = 1'b1;
               end else begin
                  wr_raw.upd_flags[F_PRIVATE] = 1'b0;
                  wr_raw.upd_flags[F_LOCK]    = 1'b0;
               end
            end else begin
               prv_in = lk.flags[F_PRIVATE];
            end
         end
         OP_WALK: begin
            if (!lk.hit) begin
               prv_in = 1'b1;
            end else if (foreign) begin
               wr_raw.upd_we    = 1'b1;
               wr_raw.upd_flags = lk.flags;
               if (lk.flags[F_RELEASE]) begin
                  wr_raw.upd_flags[F_PRIVATE] = 1'b0;
                  wr_raw.upd_flags[F_LOCK]    = 1'b0;
                  wr_raw.upd_flags[F_RELEASE] = 1'b0;
               end else begin
                  prv_in  = 1'b1;
                  trig_in = 1'b1;
                  wr_raw.upd_flags[F_LOCK]    = 1'b1;
                  wr_raw.upd_flags[F_RELEASE] = 1'b1;
               end
            end
         end
         OP_QUERY: begin
            prv_in = lk.hit && lk.flags[F_PRIVATE];
         end
         OP_RECORD: begin
            present_in = s1_pbit_ff;
            if (!s1_pbit_ff) begin
               // entry not present: lookup result ignored, everything zero
               hit_in    = 1'b0;
               keeper_in = '0;
            end else if (!lk.hit) begin
               prv_in    = 1'b1;
               keeper_in = s1_req_ff;
               insert    = 1'b1;
            end else if (foreign) begin
               trig_in          = 1'b1;
               wr_raw.upd_we    = 1'b1;
               wr_raw.upd_flags = lk.flags;
               wr_raw.upd_flags[F_PRIVATE] = 1'b0;
            end else begin
               prv_in = lk.flags[F_PRIVATE];
            end
         end
         default: begin
            prv_in = 1'b0;
         end
      endcase
      if (insert) begin
         full_in          = !lk.room;
         wr_raw.ins_we    = lk.room;
         wr_raw.ins_flags = ins_base | (FLAG_W'(1) << F_PRIVATE) | FLAG_W'(s1_req_ff);
      end
   end

   always_comb begin
      wr        = wr_raw;
      wr.upd_we = wr_raw.upd_we && fire;
      wr.ins_we = wr_raw.ins_we && fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         prv_ff     <= prv_in;
         trig_ff    <= trig_in;
         keeper_ff  <= keeper_in;
         hit_ff     <= hit_in;
         present_ff <= present_in;
         full_ff    <= full_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_is_private    = prv_ff;
   assign rsp_trigger       = trig_ff;
   assign rsp_keeper        = keeper_ff;
   assign rsp_hit           = hit_ff;
   assign rsp_entry_present = present_ff;
   assign rsp_table_full    = full_ff;

`ifndef SYNTHESIS
   a_full_is_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> !rsp_hit && rsp_is_private && !rsp_trigger)
      else $error("table_full reported on a hit or with a non-private verdict");

   a_trigger_needs_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_trigger |-> rsp_hit)
      else $error("trigger without a matching entry");

   a_insert_on_miss: assert property (@(posedge clock) disable iff (reset)
      wr.ins_we |-> fire && !lk.hit && lk.room && !wr.upd_we)
      else $error("insert issued on a hit or into a full table");

   a_update_on_hit: assert property (@(posedge clock) disable iff (reset)
      wr.upd_we |-> fire && lk.hit)
      else $error("flag update without a matching entry");
`endif

endmodule

`default_nettype wire

### hw/rtl/pspc_table.sv
// Page table store: tag CAM, flag words and fill count.
// Depends on pspc_pkg. Entries fill in index order and are never removed.
`default_nettype none

module pspc_table
   import pspc_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [TAG_W-1:0] lk_tag,
   output lookup_type            lk,
   input  write_type             wr
);

   logic [TAG_W-1:0]  tags_ff  [TABLE_ENTRIES];
   logic [FLAG_W-1:0] flags_ff [TABLE_ENTRIES];
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [TABLE_ENTRIES-1:0] match;

   // valid entries form a prefix, so the fill count stands in for valid bits
   always_comb begin
      lk.flags = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         match[i] = (CNT_W'(i) < count_ff) && (tags_ff[i] == lk_tag);
         if (match[i]) begin
            lk.flags = lk.flags | flags_ff[i];
         end
      end
      lk.hit  = |match;
      lk.room = (count_ff != CNT_W'(TABLE_ENTRIES));
   end

   assign count_in = count_ff + CNT_W'(wr.ins_we);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.ins_we) begin
         tags_ff[count_ff[IDX_W-1:0]]  <= lk_tag;
         flags_ff[count_ff[IDX_W-1:0]] <= wr.ins_flags;
      end
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (wr.upd_we && match[i]) begin
            flags_ff[i] <= wr.upd_flags;
         end
      end
   end

endmodule

`default_nettype wire
